[rtl/assert_macros.svh]
// shared assertion macros for the chunk framer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property checked at every rising clock edge outside reset
`define RCF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication checked outside reset
`define RCF_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define RCF_ASSERT(lbl, clk, rst, prop, msg)
`define RCF_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)

`endif

`endif

[rtl/rcf_pkg.sv]
package rcf_pkg;

   localparam logic        KIND_HEADER         = 1'b0;
   localparam logic        KIND_BODY           = 1'b1;
   localparam logic [1:0]  FMT_HEADER          = 2'd0;
   localparam logic [1:0]  FMT_SEPARATOR       = 2'd3;
   localparam logic [16:0] CSID_ONE_BYTE_LIMIT = 17'd64;
   localparam logic [16:0] CSID_TWO_BYTE_LIMIT = 17'd319;
   localparam logic [16:0] CSID_MAX            = 17'd65599;
   localparam logic [31:0] TS_ESCAPE           = 32'h00ff_ffff;
   localparam logic [23:0] CHUNK_SIZE_RESET    = 24'd128;
   localparam logic [4:0]  HEADER_FIXED_BYTES  = 5'd11;
   localparam logic [4:0]  EXT_TS_BYTES        = 5'd4;
   localparam logic [4:0]  ONE_BYTE            = 5'd1;

   typedef enum logic [1:0] {
      OP_HEADER,
      OP_BODY,
      OP_ERROR
   } op_type;

   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      len;
   } basic_type;

   // one classified transaction handed from front to back
   typedef struct packed {
      op_type      op;
      logic [4:0]  nbytes;
      basic_type   basic;
      logic        ext;
      logic [31:0] timestamp;
      logic [23:0] length;
      logic [7:0]  type_id;
      logic [31:0] stream_id;
      logic [7:0]  data;
   } cmd_type;

   function automatic basic_type basic_header(input logic [1:0] fmt, input logic [16:0] id);
      basic_type   b;
      logic [16:0] v;
      v       = id - CSID_ONE_BYTE_LIMIT;
      b.bytes = '0;
      if (id < CSID_ONE_BYTE_LIMIT) begin
         b.bytes[0] = {fmt, id[5:0]};
         b.len      = 2'd1;
      end else if (id <= CSID_TWO_BYTE_LIMIT) begin
         b.bytes[0] = {fmt, 6'd0};
         b.bytes[1] = v[7:0];
         b.len      = 2'd2;
      end else begin
         b.bytes[0] = {fmt, 6'd1};
         b.bytes[1] = v[7:0];
         b.bytes[2] = v[15:8];
         b.len      = 2'd3;
      end
      return b;
   endfunction

endpackage

[rtl/rcf_front.sv]
`include "assert_macros.svh"

module rcf_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [23:0]          csr_wdata,
   input  logic                 req_push,
   input  logic                 q_full,
   input  logic                 req_kind,
   input  logic [16:0]          req_chunk_stream_id,
   input  logic [31:0]          req_msg_timestamp,
   input  logic [23:0]          req_message_length,
   input  logic [7:0]           req_type_id,
   input  logic [31:0]          req_message_stream_id,
   input  logic [7:0]           req_data_byte,
   output logic                 cmd_push,
   output rcf_pkg::cmd_type     cmd
);

   logic [23:0] chunk_size_ff;
   logic [23:0] bytes_left_ff, bytes_left_in;
   logic [23:0] chunk_fill_ff, chunk_fill_in;
   logic [16:0] current_stream_ff, current_stream_in;
   logic        accept;
   logic [23:0] left_dec;
   logic [23:0] fill_inc;

   assign accept   = req_push && !q_full;
   assign cmd_push = accept;
   assign left_dec = bytes_left_ff - 24'd1;
   assign fill_inc = chunk_fill_ff + 24'd1;

   always_comb begin
      bytes_left_in     = bytes_left_ff;
      chunk_fill_in     = chunk_fill_ff;
      current_stream_in = current_stream_ff;
      cmd.op        = rcf_pkg::OP_ERROR;
      cmd.nbytes    = rcf_pkg::ONE_BYTE;
      cmd.basic     = rcf_pkg::basic_header(rcf_pkg::FMT_HEADER, req_chunk_stream_id);
      cmd.ext       = req_msg_timestamp >= rcf_pkg::TS_ESCAPE;
      cmd.timestamp = req_msg_timestamp;
      cmd.length    = req_message_length;
      cmd.type_id   = req_type_id;
      cmd.stream_id = req_message_stream_id;
      cmd.data      = req_data_byte;
      if (req_kind == rcf_pkg::KIND_HEADER) begin
         if (req_chunk_stream_id > rcf_pkg::CSID_MAX) begin
            // bad id drops the current message
            bytes_left_in = '0;
            chunk_fill_in = '0;
         end else begin
            cmd.op            = rcf_pkg::OP_HEADER;
            cmd.nbytes        = {3'd0, cmd.basic.len} + rcf_pkg::HEADER_FIXED_BYTES
                                + (cmd.ext ? rcf_pkg::EXT_TS_BYTES : 5'd0);
            bytes_left_in     = req_message_length;
            chunk_fill_in     = '0;
            current_stream_in = req_chunk_stream_id;
         end
      end else if (bytes_left_ff != '0) begin
         cmd.op        = rcf_pkg::OP_BODY;
         cmd.basic     = rcf_pkg::basic_header(rcf_pkg::FMT_SEPARATOR, current_stream_ff);
         bytes_left_in = left_dec;
         if (left_dec == '0) begin
            chunk_fill_in = '0;
         end else if (fill_inc >= chunk_size_ff) begin
            // chunk full with more to come: type-3 separator follows the byte
            cmd.nbytes    = rcf_pkg::ONE_BYTE + {3'd0, cmd.basic.len};
            chunk_fill_in = '0;
         end else begin
            chunk_fill_in = fill_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_size_ff     <= rcf_pkg::CHUNK_SIZE_RESET;
         bytes_left_ff     <= '0;
         chunk_fill_ff     <= '0;
         current_stream_ff <= '0;
      end else begin
         if (csr_we) begin
            chunk_size_ff <= csr_wdata;
         end
         if (accept) begin
            bytes_left_ff     <= bytes_left_in;
            chunk_fill_ff     <= chunk_fill_in;
            current_stream_ff <= current_stream_in;
         end
      end
   end

   `RCF_ASSERT_IMPLY(a_fill_idle, clock, reset, bytes_left_ff == '0, chunk_fill_ff == '0, "chunk fill set with no message")
   `RCF_ASSERT(a_stream_range, clock, reset, current_stream_ff <= rcf_pkg::CSID_MAX, "current stream id out of range")

endmodule

[rtl/rcf_queue.sv]
`include "assert_macros.svh"

module rcf_queue #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rcf_pkg::cmd_type     push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 head_valid,
   output rcf_pkg::cmd_type     head
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   rcf_pkg::cmd_type   mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push_ok;
   logic               pop_ok;

   assign full       = count_ff == CNT_W'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head       = mem_ff[rd_ptr_ff];
   assign push_ok    = push && !full;
   assign pop_ok     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `RCF_ASSERT_IMPLY(a_empty_ptrs, clock, reset, count_ff == '0, rd_ptr_ff == wr_ptr_ff, "queue empty but pointers differ")

endmodule

[rtl/rcf_back.sv]
`include "assert_macros.svh"

module rcf_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  rcf_pkg::cmd_type     head,
   output logic                 head_pop,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_last,
   output logic                 rsp_error
);

   logic [4:0]  idx_ff, idx_in;
   logic        rsp_valid_ff;
   logic [7:0]  byte_ff;
   logic        last_ff;
   logic        error_ff;
   logic        load;
   logic        is_last;
   logic [4:0]  tail_idx;
   logic [23:0] ts24;
   logic [7:0]  byte_sel;

   assign load     = head_valid && (!rsp_valid_ff || rsp_pop);
   assign is_last  = idx_ff == (head.nbytes - 5'd1);
   assign head_pop = load && is_last;
   assign idx_in   = load ? (is_last ? 5'd0 : idx_ff + 5'd1) : idx_ff;
   assign tail_idx = idx_ff - {3'd0, head.basic.len};
   assign ts24     = head.ext ? rcf_pkg::TS_ESCAPE[23:0] : head.timestamp[23:0];

   always_comb begin
      byte_sel = 8'h00;
      unique case (head.op)
         rcf_pkg::OP_HEADER: begin
            if (idx_ff < {3'd0, head.basic.len}) begin
               byte_sel = head.basic.bytes[idx_ff[1:0]];
            end else begin
               // fixed part, then any extended timestamp, after the basic header
               unique case (tail_idx[3:0])
                  4'd0:    byte_sel = ts24[23:16];
                  4'd1:    byte_sel = ts24[15:8];
                  4'd2:    byte_sel = ts24[7:0];
                  4'd3:    byte_sel = head.length[23:16];
                  4'd4:    byte_sel = head.length[15:8];
                  4'd5:    byte_sel = head.length[7:0];
                  4'd6:    byte_sel = head.type_id;
                  4'd7:    byte_sel = head.stream_id[7:0];
                  4'd8:    byte_sel = head.stream_id[15:8];
                  4'd9:    byte_sel = head.stream_id[23:16];
                  4'd10:   byte_sel = head.stream_id[31:24];
                  4'd11:   byte_sel = head.timestamp[31:24];
                  4'd12:   byte_sel = head.timestamp[23:16];
                  4'd13:   byte_sel = head.timestamp[15:8];
                  4'd14:   byte_sel = head.timestamp[7:0];
                  default: byte_sel = 8'h00;
               endcase
            end
         end
         rcf_pkg::OP_BODY: begin
            // body byte, then the separator if one was planned
            if (idx_ff == 5'd0) begin
               byte_sel = head.data;
            end else begin
               byte_sel = head.basic.bytes[idx_ff[1:0] - 2'd1];
            end
         end
         rcf_pkg::OP_ERROR: byte_sel = 8'h00;
         default:           byte_sel = 8'h00;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff  <= byte_sel;
         last_ff  <= is_last;
         error_ff <= head.op == rcf_pkg::OP_ERROR;
      end
   end

   assign rsp_empty    = !rsp_valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_last     = last_ff;
   assign rsp_error    = error_ff;

   `RCF_ASSERT_IMPLY(a_idx_bound, clock, reset, head_valid, idx_ff < head.nbytes, "byte index past end of transaction")
   `RCF_ASSERT_IMPLY(a_idx_idle, clock, reset, !head_valid, idx_ff == 5'd0, "byte index moved with no transaction")

endmodule

[rtl/rtmp_chunk_framer_unit.sv]
// each transaction is stored in the command queue, then its bytes in the back's output register
// throughput: one output byte per cycle while rsp_pop is high; a header is 12 to 18 bytes,
// a body byte 1, or 2 to 4 when a type-3 separator follows; the back's serializer sets this
// the command queue (QUEUE_DEPTH entries) lets new transactions enter while bytes drain
// reset (synchronous, active high): chunk size 128, message state zero, queue and output empty

module rtmp_chunk_framer_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [23:0] csr_wdata,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_kind,
   input  logic [16:0] req_chunk_stream_id,
   input  logic [31:0] req_msg_timestamp,
   input  logic [23:0] req_message_length,
   input  logic [7:0]  req_type_id,
   input  logic [31:0] req_message_stream_id,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last,
   output logic        rsp_error
);

   rcf_pkg::cmd_type cmd;
   rcf_pkg::cmd_type head;
   logic             cmd_push;
   logic             q_full;
   logic             head_valid;
   logic             head_pop;

   assign req_full = q_full;

   rcf_front u_front (
      .clock                 (clock),
      .reset                 (reset),
      .csr_we                (csr_we),
      .csr_wdata             (csr_wdata),
      .req_push              (req_push),
      .q_full                (q_full),
      .req_kind              (req_kind),
      .req_chunk_stream_id   (req_chunk_stream_id),
      .req_msg_timestamp     (req_msg_timestamp),
      .req_message_length    (req_message_length),
      .req_type_id           (req_type_id),
      .req_message_stream_id (req_message_stream_id),
      .req_data_byte         (req_data_byte),
      .cmd_push              (cmd_push),
      .cmd                   (cmd)
   );

   rcf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_data  (cmd),
      .full       (q_full),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head       (head)
   );

   rcf_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head         (head),
      .head_pop     (head_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last),
      .rsp_error    (rsp_error)
   );

endmodule

[verif/rtmp_chunk_framer_unit_tb.sv]
module rtmp_chunk_framer_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct packed {
      logic        kind;
      logic [16:0] csid;
      logic [31:0] timestamp;
      logic [23:0] length;
      logic [7:0]  type_id;
      logic [31:0] stream_id;
      logic [7:0]  data;
   } chunk_request_type;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
      logic       err;
   } stream_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [23:0] csr_wdata = '0;
   logic        req_push = 1'b0;
   logic        req_full;
   logic        req_kind = 1'b0;
   logic [16:0] req_chunk_stream_id = '0;
   logic [31:0] req_msg_timestamp = '0;
   logic [23:0] req_message_length = '0;
   logic [7:0]  req_type_id = '0;
   logic [31:0] req_message_stream_id = '0;
   logic [7:0]  req_data_byte = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last;
   logic        rsp_error;

   rtmp_chunk_framer_unit dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // framer state as the block should hold it
   logic [23:0] chunk_size = rcf_pkg::CHUNK_SIZE_RESET;
   logic [23:0] msg_bytes_left = '0;
   logic [23:0] chunk_fill = '0;
   logic [16:0] cur_csid = '0;

   chunk_request_type request_queue[$];
   stream_byte_type   expected_bytes[$];

   chunk_request_type tx_item = '0;
   bit             tx_offering = 1'b0;
   int             tx_gap = 0;
   bit             tx_gaps_on = 1'b1;
   bit             rx_popping = 1'b0;
   int             rx_stall = 0;
   bit             rx_stalls_on = 1'b1;
   int             rx_hold_cycles = 0;
   int             mismatch_count = 0;
   int             idle_cycles = 0;

   function automatic void push_byte(input logic [7:0] value);
      expected_bytes.push_back('{value: value, last: 1'b0, err: 1'b0});
   endfunction

   function automatic void push_basic(input logic [1:0] fmt, input logic [16:0] id);
      logic [16:0] v;
      v = id - rcf_pkg::CSID_ONE_BYTE_LIMIT;
      if (id < rcf_pkg::CSID_ONE_BYTE_LIMIT) begin
         push_byte({fmt, id[5:0]});
      end else if (id <= rcf_pkg::CSID_TWO_BYTE_LIMIT) begin
         push_byte({fmt, 6'd0});
         push_byte(v[7:0]);
      end else begin
         push_byte({fmt, 6'd1});
         push_byte(v[7:0]);
         push_byte(v[15:8]);
      end
   endfunction

   // expected stream bytes for one accepted transaction
   function automatic void frame_request(input chunk_request_type r);
      logic [23:0] ts24;
      if (r.kind == rcf_pkg::KIND_HEADER) begin
         if (r.csid > rcf_pkg::CSID_MAX) begin
            msg_bytes_left = '0;
            chunk_fill     = '0;
            expected_bytes.push_back('{value: 8'h00, last: 1'b1, err: 1'b1});
            return;
         end
         ts24 = (r.timestamp >= rcf_pkg::TS_ESCAPE) ? rcf_pkg::TS_ESCAPE[23:0]
                                                    : r.timestamp[23:0];
         push_basic(rcf_pkg::FMT_HEADER, r.csid);
         push_byte(ts24[23:16]);
         push_byte(ts24[15:8]);
         push_byte(ts24[7:0]);
         push_byte(r.length[23:16]);
         push_byte(r.length[15:8]);
         push_byte(r.length[7:0]);
         push_byte(r.type_id);
         push_byte(r.stream_id[7:0]);
         push_byte(r.stream_id[15:8]);
         push_byte(r.stream_id[23:16]);
         push_byte(r.stream_id[31:24]);
         if (r.timestamp >= rcf_pkg::TS_ESCAPE) begin
            push_byte(r.timestamp[31:24]);
            push_byte(r.timestamp[23:16]);
            push_byte(r.timestamp[15:8]);
            push_byte(r.timestamp[7:0]);
         end
         msg_bytes_left = r.length;
         chunk_fill     = '0;
         cur_csid       = r.csid;
      end else begin
         if (msg_bytes_left == 0) begin
            expected_bytes.push_back('{value: 8'h00, last: 1'b1, err: 1'b1});
            return;
         end
         push_byte(r.data);
         msg_bytes_left = msg_bytes_left - 24'd1;
         chunk_fill     = chunk_fill + 24'd1;
         if (msg_bytes_left == 0) begin
            chunk_fill = '0;
         end else if (chunk_fill >= chunk_size) begin
            push_basic(rcf_pkg::FMT_SEPARATOR, cur_csid);
            chunk_fill = '0;
         end
      end
      expected_bytes[expected_bytes.size() - 1].last = 1'b1;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // unused fields carry random values too
   function automatic chunk_request_type random_request();
      chunk_request_type r;
      r.kind      = 1'($urandom);
      r.csid      = 17'($urandom);
      r.timestamp = $urandom;
      r.length    = 24'($urandom);
      r.type_id   = 8'($urandom);
      r.stream_id = $urandom;
      r.data      = 8'($urandom);
      return r;
   endfunction

   function automatic chunk_request_type header_req(input logic [16:0] csid,
                                                    input logic [31:0] ts,
                                                    input logic [23:0] len,
                                                    input logic [7:0]  typ,
                                                    input logic [31:0] sid);
      chunk_request_type r;
      r           = random_request();
      r.kind      = rcf_pkg::KIND_HEADER;
      r.csid      = csid;
      r.timestamp = ts;
      r.length    = len;
      r.type_id   = typ;
      r.stream_id = sid;
      return r;
   endfunction

   function automatic chunk_request_type body_req(input logic [7:0] data);
      chunk_request_type r;
      r      = random_request();
      r.kind = rcf_pkg::KIND_BODY;
      r.data = data;
      return r;
   endfunction

   function automatic logic [16:0] random_csid();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return 17'($urandom_range(0, 63));
         4, 5:       return 17'($urandom_range(64, 319));
         6, 7:       return 17'($urandom_range(320, 65599));
         8:          return 17'($urandom_range(65000, 65599));
         default:    return 17'($urandom_range(65600, 131071));
      endcase
   endfunction

   function automatic logic [31:0] random_timestamp();
      case ($urandom_range(0, 4))
         0:       return $urandom_range(0, 1000);
         1:       return rcf_pkg::TS_ESCAPE - 32'd2 + $urandom_range(0, 4);
         2:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // mostly whole messages; some cut short, overrun, or stray body bytes
   task automatic add_traffic();
      chunk_request_type hdr;
      int             body_count;
      int             roll;
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
         request_queue.push_back(body_req(8'($urandom)));
         return;
      end
      roll = $urandom_range(0, 99);
      hdr  = header_req(random_csid(), random_timestamp(), '0, 8'($urandom), $urandom);
      if (roll < 75) hdr.length = 24'($urandom_range(0, 12));
      else if (roll < 90) hdr.length = 24'($urandom_range(13, 150));
      else hdr.length = 24'($urandom);
      body_count = (hdr.length > 150) ? $urandom_range(0, 8) : int'(hdr.length);
      roll = $urandom_range(0, 99);
      if (roll < 10) body_count = body_count / 2;
      else if (roll < 18) body_count = body_count + $urandom_range(1, 2);
      request_queue.push_back(hdr);
      repeat (body_count) request_queue.push_back(body_req(8'($urandom)));
   endtask

   task automatic write_chunk_size(input logic [23:0] size);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= size;
      @(posedge clock);
      csr_we    <= 1'b0;
      chunk_size = size;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (request_queue.size() != 0 || req_push || expected_bytes.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic report_mismatch(input string what);
      if (mismatch_count < 100) $display("mismatch at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         tx_offering = 1'b0;
         tx_gap      = 0;
      end else begin
         if (tx_offering && !req_full) begin
            frame_request(tx_item);
            tx_offering = 1'b0;
            tx_gap      = tx_gaps_on ? pick_gap() : 0;
         end
         if (!tx_offering) begin
            if (tx_gap > 0) begin
               tx_gap--;
            end else if (request_queue.size() > 0) begin
               tx_item     = request_queue.pop_front();
               tx_offering = 1'b1;
            end
         end
      end
      req_push              <= tx_offering;
      req_kind              <= tx_item.kind;
      req_chunk_stream_id   <= tx_item.csid;
      req_msg_timestamp     <= tx_item.timestamp;
      req_message_length    <= tx_item.length;
      req_type_id           <= tx_item.type_id;
      req_message_stream_id <= tx_item.stream_id;
      req_data_byte         <= tx_item.data;
   end

   // monitor
   always @(posedge clock) begin
      stream_byte_type want;
      if (reset) begin
         rx_popping = 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch($sformatf("unexpected transaction byte %02h last %b error %b",
                                         rsp_out_byte, rsp_last, rsp_error));
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_out_byte !== want.value || rsp_last !== want.last ||
                   rsp_error !== want.err)
                  report_mismatch($sformatf("got byte %02h last %b error %b, want %02h %b %b",
                                            rsp_out_byte, rsp_last, rsp_error,
                                            want.value, want.last, want.err));
            end
         end
         if (rx_hold_cycles > 0) begin
            rx_hold_cycles--;
            rx_popping = 1'b0;
         end else if (rx_stall > 0) begin
            rx_stall--;
            rx_popping = 1'b0;
         end else begin
            rx_popping = 1'b1;
            if (rx_stalls_on) rx_stall = pick_gap();
         end
      end
      rsp_pop <= rx_popping;
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // basic header sizes, timestamp escape, zero length, errors
      request_queue.push_back(body_req(8'h3C));
      request_queue.push_back(header_req(17'd0, 32'd0, 24'd3, 8'h00, 32'h0000_0000));
      request_queue.push_back(body_req(8'h00));
      request_queue.push_back(body_req(8'hFF));
      request_queue.push_back(body_req(8'h5A));
      request_queue.push_back(header_req(17'd63, 32'h00FF_FFFE, 24'd0, 8'hFF, 32'hFFFF_FFFF));
      request_queue.push_back(body_req(8'h11));
      request_queue.push_back(header_req(17'd64, 32'h00FF_FFFF, 24'd2, 8'h12, 32'h1234_5678));
      request_queue.push_back(body_req(8'h01));
      // new header while the previous message is still open
      request_queue.push_back(header_req(17'd319, 32'hFFFF_FFFF, 24'hFF_FFFF, 8'h80,
                                         32'h8000_0001));
      request_queue.push_back(body_req(8'hA5));
      request_queue.push_back(body_req(8'h5A));
      request_queue.push_back(header_req(17'd320, 32'h0100_0000, 24'd1, 8'h09, 32'd1));
      request_queue.push_back(body_req(8'h77));
      request_queue.push_back(header_req(17'd65599, 32'd1234, 24'd2, 8'h14, 32'd7));
      request_queue.push_back(body_req(8'h88));
      // bad id drops the open message
      request_queue.push_back(header_req(17'd65600, 32'd5, 24'd4, 8'h08, 32'd2));
      request_queue.push_back(body_req(8'h99));
      request_queue.push_back(header_req(17'd131071, 32'd6, 24'd1, 8'h08, 32'd3));
      wait_drained();

      // chunk size zero acts as one, three-byte separators
      write_chunk_size(24'd0);
      request_queue.push_back(header_req(17'd400, 32'd10, 24'd3, 8'h09, 32'd1));
      repeat (3) request_queue.push_back(body_req(8'($urandom)));
      wait_drained();

      // size shrinks in the middle of a chunk
      write_chunk_size(24'd128);
      request_queue.push_back(header_req(17'd70, 32'd20, 24'd4, 8'h08, 32'd1));
      repeat (2) request_queue.push_back(body_req(8'($urandom)));
      wait_drained();
      write_chunk_size(24'd1);
      repeat (2) request_queue.push_back(body_req(8'($urandom)));
      wait_drained();

      for (int phase = 0; phase < 6; phase++) begin
         tx_gaps_on   = !(phase inside {4, 5});
         rx_stalls_on = (phase != 1) && (phase != 5);
         case (phase)
            0:       write_chunk_size(24'hFF_FFFF);
            1:       write_chunk_size(24'd1);
            2:       write_chunk_size(24'd0);
            3:       write_chunk_size(24'($urandom_range(2, 20)));
            4:       write_chunk_size(24'd16);
            default: write_chunk_size(24'd128);
         endcase
         // receiver backs off while the sender keeps pushing
         if (phase == 4) rx_hold_cycles = 400;
         while (request_queue.size() < 30) add_traffic();
         wait_drained();
      end

      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && expected_bytes.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
